/* rtl/rits_pkg.sv */
// ----------------------------------------------------------------------------
// rits_pkg - shared types and constants for the radix symbol writer
// Character codes, symbol alphabet size, digit width and the mapping from
// symbol position to its ASCII code.
// ----------------------------------------------------------------------------
`default_nettype none

package rits_pkg;

  // Alphabet: 0-9, A-Z, a-z in ASCII order
  localparam int SYM_BITS = 62;
  // One digit or symbol position fits in six bits
  localparam int DIGIT_W  = 6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic STATUS_OK           = 1'b0;
  localparam logic STATUS_BAD_ALPHABET = 1'b1;

  typedef logic [SYM_BITS-1:0] sym_mask_t;
  typedef logic [DIGIT_W-1:0]  digit_t;

  // ASCII code of the k-th alphanumeric
  function automatic logic [7:0] symbol_code(input digit_t k);
    logic [7:0] kk;
    kk = {2'b00, k};
    if (kk <= (CH_9 - CH_0)) begin
      symbol_code = CH_0 + kk;
    end else if (kk <= (CH_9 - CH_0) + (CH_UZ - CH_UA) + 8'd1) begin
      symbol_code = CH_UA + kk - 8'd10;
    end else begin
      symbol_code = CH_LA + kk - 8'd36;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/radix_integer_to_symbols.sv */
// ----------------------------------------------------------------------------
// radix_integer_to_symbols - signed integer to ASCII text in a chosen base
// Writes a VALUE_BITS signed value as characters in the base set by the
// symbol mask, most significant digit first, with a leading '-' when negative.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a value is taken at a clock edge with start high and busy low.
//   Config: symbol_mask is written through cfg_valid/cfg_ready/cfg_data; the
//     port is ready whenever the block is idle and start is low. Bit k selects
//     the k-th alphanumeric (0-9, A-Z, a-z) for the alphabet; the base is its
//     popcount.
//   Output: each character is shown for one cycle with strobe high; last
//     marks the final character of a run. An alphabet of fewer than two
//     symbols gives one result with out_char 0, last 1 and status 1.
//   Timing: the first value after reset or a mask write scans the mask, one
//     bit a cycle, building the digit-to-symbol table. Each digit then goes
//     through the bit-serial divider, and each digit character through a
//     buffer read, a table read and the output register.
//   Reset: mask returns to the decimal digits, all runs are dropped.
//   The receiver cannot stall; characters are never held back.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_integer_to_symbols #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [VALUE_BITS-1:0] value,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire rits_pkg::sym_mask_t          cfg_data,
  output logic                              strobe,
  output logic [7:0]                        out_char,
  output logic                              last,
  output logic                              status
);
  import rits_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W:0] MAX_D = (CNT_W + 1)'(MAX_DIGITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_DIV,
    ST_RD_BUF,
    ST_RD_POS,
    ST_OUT
  } state_t;

  state_t              state;
  sym_mask_t           symbol_mask;
  sym_mask_t           scan_sh;
  digit_t              scan_idx;
  digit_t              base;
  logic                dirty;
  logic                neg;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] value_u;
  logic [CNT_W-1:0]    wr_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic                div_load;
  logic                div_done;
  logic [VALUE_BITS-1:0] div_quo;
  digit_t              div_rem;
  logic                more;

  digit_t              digit_mem [MAX_DIGITS];
  digit_t              pos_mem   [SYM_BITS];
  digit_t              buf_q;
  digit_t              pos_q;

  assign busy      = (state != ST_IDLE);
  // Hold off mask writes while a transaction is being accepted
  assign cfg_ready = (state == ST_IDLE) && !start;
  assign value_u   = value;
  // Keep dividing while digits remain and the buffer has room
  assign more      = (div_quo != '0) && (({1'b0, wr_idx} + (CNT_W + 1)'(1)) < MAX_D);

  rits_divider #(
    .WIDTH(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend (mag),
    .divisor  (base),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Digit buffer and symbol position table
  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_done) begin
      digit_mem[wr_idx[IDX_W-1:0]] <= div_rem;
    end
    if (state == ST_SCAN && scan_sh[0]) begin
      pos_mem[base] <= scan_idx;
    end
    buf_q <= digit_mem[rd_idx];
    pos_q <= pos_mem[buf_q];
  end

  // Sequencer, configuration register and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      symbol_mask <= SYM_BITS'(1023);
      dirty       <= 1'b1;
      base        <= '0;
      div_load    <= 1'b0;
      strobe      <= 1'b0;
      last        <= 1'b0;
      status      <= STATUS_OK;
      out_char    <= CH_NUL;
    end else begin
      strobe   <= 1'b0;
      div_load <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        symbol_mask <= cfg_data;
        dirty       <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            neg      <= value_u[VALUE_BITS-1];
            mag      <= value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
            scan_sh  <= symbol_mask;
            scan_idx <= '0;
            if (dirty) begin
              base  <= '0;
              state <= ST_SCAN;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_SCAN: begin
          // Count alphabet members and record each one's position
          if (scan_sh[0]) begin
            base <= base + DIGIT_W'(1);
          end
          scan_sh  <= scan_sh >> 1;
          scan_idx <= scan_idx + DIGIT_W'(1);
          if (scan_idx == DIGIT_W'(SYM_BITS - 1)) begin
            dirty <= 1'b0;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (base < DIGIT_W'(2)) begin
            strobe   <= 1'b1;
            out_char <= CH_NUL;
            last     <= 1'b1;
            status   <= STATUS_BAD_ALPHABET;
            state    <= ST_IDLE;
          end else begin
            wr_idx   <= '0;
            div_load <= 1'b1;
            state    <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            mag <= div_quo;
            if (more) begin
              wr_idx   <= wr_idx + CNT_W'(1);
              div_load <= 1'b1;
            end else begin
              rd_idx <= wr_idx[IDX_W-1:0];
              // Sign leads the digits
              if (neg) begin
                strobe   <= 1'b1;
                out_char <= CH_MINUS;
                last     <= 1'b0;
                status   <= STATUS_OK;
              end
              state <= ST_RD_BUF;
            end
          end
        end
        ST_RD_BUF: begin
          state <= ST_RD_POS;
        end
        ST_RD_POS: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          strobe   <= 1'b1;
          out_char <= symbol_code(pos_q);
          last     <= (rd_idx == '0);
          status   <= STATUS_OK;
          if (rd_idx == '0) begin
            state <= ST_IDLE;
          end else begin
            rd_idx <= rd_idx - IDX_W'(1);
            state  <= ST_RD_BUF;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/rits_divider.sv */
// ----------------------------------------------------------------------------
// rits_divider - bit-serial restoring divider by a small radix
// Divides a WIDTH-bit magnitude by a six-bit base, one quotient bit per
// cycle; quotient and remainder are ready with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module rits_divider #(
  parameter int WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic [WIDTH-1:0]      dividend,
  input  wire rits_pkg::digit_t      divisor,
  output logic                       done,
  output logic [WIDTH-1:0]           quotient,
  output rits_pkg::digit_t           remainder
);
  import rits_pkg::*;

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]   quo;
  digit_t             rem;
  logic [CNT_W-1:0]   cnt;
  logic               running;
  logic [DIGIT_W:0]   shifted;
  logic [DIGIT_W:0]   diff;
  logic               fits;

  // Trial subtraction of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[WIDTH-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = shifted >= {1'b0, divisor};
  end

  // Shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        cnt     <= CNT_W'(WIDTH);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (load) begin
      quo <= dividend;
      rem <= '0;
    end else if (running) begin
      quo <= {quo[WIDTH-2:0], fits};
      rem <= fits ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

/* rtl/rits_checker.sv */
// ----------------------------------------------------------------------------
// rits_checker - port-level checks for the radix symbol writer
// Watches the command, result and configuration ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rits_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       cfg_ready,
  input wire logic       strobe,
  input wire logic [7:0] out_char,
  input wire logic       last,
  input wire logic       status
);
  import rits_pkg::*;

  // An accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  // Busy only rises on an accepted transaction
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // Error result is a single, final, empty character
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == STATUS_BAD_ALPHABET) |-> last && (out_char == CH_NUL))
    else $error("malformed error result");

  // A run's final character is followed by a quiet cycle
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result straight after final character");

  // Characters before the final one appear while the run is in progress
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy && !cfg_ready)
    else $error("intermediate character while idle");

endmodule

bind radix_integer_to_symbols rits_checker u_rits_checker (.*);

`default_nettype wire

/* tb/tb_radix_integer_to_symbols.sv */
// ----------------------------------------------------------------------------
// tb_radix_integer_to_symbols - self-checking bench for the radix text writer
// Sends signed 32-bit values under a series of symbol masks and compares
// every emitted character, with its last and status flags, against text
// worked out here from the current alphabet. Directed cases cover the
// default decimal alphabet, bad alphabets, base 2 and base 62; random phases
// then draw fresh masks and values, with random gaps on the command side.
// ----------------------------------------------------------------------------
module tb_radix_integer_to_symbols;
  import rits_pkg::*;

  localparam int VALUE_W         = 32;
  localparam int MAX_DIGITS      = 32;
  localparam int GAP_MAX         = 4;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int CYCLE_LIMIT     = 3_000_000;

  localparam sym_mask_t MASK_DECIMAL = sym_mask_t'(1023);
  localparam sym_mask_t MASK_FULL    = {SYM_BITS{1'b1}};
  localparam sym_mask_t MASK_NONE    = '0;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  // One expected character of a value's text
  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
    logic       stat;
  } text_char_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      cfg_valid = 1'b0;
  sym_mask_t                 cfg_data = '0;
  logic                      busy;
  logic                      cfg_ready;
  logic                      strobe;
  logic [7:0]                out_char;
  logic                      last;
  logic                      status;

  // Local copy of the alphabet register and the expected text
  sym_mask_t  mask_model = MASK_DECIMAL;
  text_char_t pending_chars[$];
  text_char_t want_char;

  int  cycle_count   = 0;
  int  error_count   = 0;
  int  values_sent   = 0;
  int  chars_checked = 0;
  int  masks_written = 0;
  bit  quiet_sender  = 1'b0;

  radix_integer_to_symbols #(
    .VALUE_BITS (VALUE_W),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .out_char  (out_char),
    .last      (last),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d characters still pending",
               cycle_count, pending_chars.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // ASCII code of the k-th alphanumeric in 0-9, A-Z, a-z order
  function automatic logic [7:0] alnum_code(input int k);
    if (k < 10) begin
      return CH_0 + 8'(k);
    end else if (k < 36) begin
      return CH_UA + 8'(k - 10);
    end
    return CH_LA + 8'(k - 36);
  endfunction

  // Work out the text of one value under the current alphabet
  task automatic predict_text(input logic signed [VALUE_W-1:0] v);
    logic [7:0]         alpha [0:SYM_BITS-1];
    logic [5:0]         digs  [0:MAX_DIGITS-1];
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] radix;
    int                 base;
    int                 n;
    int                 k;
    base = 0;
    for (k = 0; k < SYM_BITS; k++) begin
      if (mask_model[k]) begin
        alpha[base] = alnum_code(k);
        base++;
      end
    end
    if (base < 2) begin
      pending_chars.push_back('{CH_NUL, 1'b1, STATUS_BAD_ALPHABET});
      return;
    end
    radix = VALUE_W'(base);
    // magnitude as unsigned, so the most negative value survives
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    n = 0;
    do begin
      digs[n] = 6'(mag % radix);
      mag     = mag / radix;
      n++;
    end while (mag != 0 && n < MAX_DIGITS);
    if (v[VALUE_W-1]) begin
      pending_chars.push_back('{CH_MINUS, 1'b0, STATUS_OK});
    end
    for (k = n - 1; k >= 0; k--) begin
      pending_chars.push_back('{alpha[digs[k]], (k == 0), STATUS_OK});
    end
  endtask

  // Compare each emitted character with the oldest pending one
  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", out_char));
      end else begin
        want_char = pending_chars.pop_front();
        chars_checked++;
        if (out_char !== want_char.ch)
          report_mismatch($sformatf("out_char 0x%02h, want 0x%02h", out_char, want_char.ch));
        if (last !== want_char.is_last)
          report_mismatch($sformatf("last %b, want %b", last, want_char.is_last));
        if (status !== want_char.stat)
          report_mismatch($sformatf("status %b, want %b", status, want_char.stat));
      end
    end
  end

  // Issue one value as a transaction, after a random gap unless the sender is quiet
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    predict_text(v);
    values_sent++;
  endtask

  // Drop start and hold until every expected character has arrived
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the alphabet register; only called with the block idle
  task automatic write_symbol_mask(input sym_mask_t m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid  <= 1'b0;
    mask_model = m;
    masks_written++;
  endtask

  function automatic sym_mask_t sparse_mask(input int bits);
    sym_mask_t m;
    m = '0;
    repeat (bits) m[$urandom_range(0, SYM_BITS - 1)] = 1'b1;
    return m;
  endfunction

  function automatic sym_mask_t draw_mask();
    sym_mask_t m;
    case ($urandom_range(0, 7))
      0, 1, 2: m = sym_mask_t'({$urandom, $urandom});
      3, 4:    m = sparse_mask($urandom_range(2, 5));
      5:       m = MASK_FULL & ~sparse_mask($urandom_range(1, 6));
      6:       m = sym_mask_t'(3) << $urandom_range(0, SYM_BITS - 2);
      default: m = sparse_mask($urandom_range(0, 1));
    endcase
    return m;
  endfunction

  function automatic logic signed [VALUE_W-1:0] draw_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = $urandom;
      6, 7: begin
        v = $urandom_range(0, 255);
        if ($urandom_range(0, 1)) v = -v;
      end
      8:       v = $urandom_range(0, 1) ? VAL_MIN + $urandom_range(0, 3)
                                        : VAL_MAX - $urandom_range(0, 3);
      default: v = $urandom_range(0, 2) - 1;
    endcase
    return v;
  endfunction

  // Decimal alphabet straight out of reset
  task automatic test_decimal_default();
    send_value(0);
    send_value(7);
    send_value(-7);
    send_value(10);
    send_value(VAL_MAX);
    send_value(VAL_MIN);
    send_value(-1000000000);
    wait_drained();
  endtask

  // Empty and single-symbol alphabets give one error result each
  task automatic test_bad_alphabet();
    write_symbol_mask(MASK_NONE);
    send_value(5);
    send_value(-3);
    wait_drained();
    write_symbol_mask(sym_mask_t'(1) << (SYM_BITS - 1));
    send_value(0);
    send_value(VAL_MIN);
    wait_drained();
  endtask

  // Base 2 from the lowest and highest symbols: longest texts
  task automatic test_binary_alphabet();
    write_symbol_mask((sym_mask_t'(1) << (SYM_BITS - 1)) | sym_mask_t'(1));
    send_value(0);
    send_value(-1);
    send_value(VAL_MAX);
    send_value(VAL_MIN);
    wait_drained();
  endtask

  // Base 62 with every symbol selected
  task automatic test_full_alphabet();
    write_symbol_mask(MASK_FULL);
    send_value(61);
    send_value(62);
    send_value(-62);
    send_value(VAL_MIN);
    send_value(VAL_MAX);
    wait_drained();
  endtask

  // Random alphabets, each followed by a burst of random values
  task automatic test_random_alphabets();
    int phase;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_symbol_mask(draw_mask());
      quiet_sender = ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE) send_value(draw_value());
      wait_drained();
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_decimal_default();
    test_bad_alphabet();
    test_binary_alphabet();
    test_full_alphabet();
    test_random_alphabets();
    $display("Sent %0d values under %0d alphabet writes plus the reset alphabet",
             values_sent, masks_written);
    $display("Checked %0d characters, %0d mismatches", chars_checked, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
